/* rtl/pgb_pkg.sv */
// ----------------------------------------------------------------------------
// pgb_pkg
// Shared types and constants of the piecewise gain/bias pixel engine.
// ----------------------------------------------------------------------------
package pgb_pkg;

   localparam int MAX_REGIONS = 16;
   localparam int MAX_SIDE    = 64;
   localparam int MAX_SPLIT   = 4;

   localparam logic [4:0] BIAS_SLOT = 5'd16;

   localparam logic [2:0] CSR_PATCH_WIDTH    = 3'd0;
   localparam logic [2:0] CSR_PATCH_HEIGHT   = 3'd1;
   localparam logic [2:0] CSR_REGIONS_ACROSS = 3'd2;
   localparam logic [2:0] CSR_REGIONS_DOWN   = 3'd3;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   localparam logic [1:0] KIND_PIXEL    = 2'd0;
   localparam logic [1:0] KIND_GAIN_SUM = 2'd1;
   localparam logic [1:0] KIND_BIAS_SUM = 2'd2;

   typedef enum logic {
      BACK_RUN,
      BACK_DRAIN
   } back_state_type;

   typedef struct packed {
      logic        action;
      logic [4:0]  slot;
      logic [23:0] value;
      logic [3:0]  region;
      logic [15:0] intensity;
      logic [15:0] gradient;
      logic        patch_end;
   } entry_type;

   typedef struct packed {
      logic       run_clear;
      logic [3:0] nreg_last;
   } geom_type;

endpackage

/* rtl/pgb_front.sv */
// ----------------------------------------------------------------------------
// pgb_front
// Configuration registers, raster position and region classification.
// ----------------------------------------------------------------------------
module pgb_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [6:0]          csr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_action,
   input  logic [4:0]          req_param_slot,
   input  logic signed [23:0]  req_param_value,
   input  logic [15:0]         req_intensity,
   input  logic signed [15:0]  req_out_gradient,
   input  logic                q_full,
   output logic                q_push,
   output pgb_pkg::entry_type  q_entry,
   output pgb_pkg::geom_type   geom
);

   logic [6:0] width_ff, width_in;
   logic [6:0] height_ff, height_in;
   logic [2:0] across_ff, across_in;
   logic [2:0] down_ff, down_in;
   logic [6:0] col_ff, col_in;
   logic [6:0] row_ff, row_in;

   logic [6:0]  w, h;
   logic [2:0]  ax, ay;
   logic [2:0]  ax_c, ay_c;
   logic [6:0]  sx, sy;
   logic [14:0] w3, h3;
   logic [8:0]  bx1, bx2, bx3, by1, by2, by3;
   logic [1:0]  rc, rr;
   logic        csr_hit;
   logic        pix_push;
   logic        col_wrap, row_wrap;

   always_comb begin
      w = (width_ff == 7'd0) ? 7'd1 :
          (width_ff > 7'(pgb_pkg::MAX_SIDE)) ? 7'(pgb_pkg::MAX_SIDE) : width_ff;
      h = (height_ff == 7'd0) ? 7'd1 :
          (height_ff > 7'(pgb_pkg::MAX_SIDE)) ? 7'(pgb_pkg::MAX_SIDE) : height_ff;
      ax_c = (across_ff == 3'd0) ? 3'd1 :
             (across_ff > 3'(pgb_pkg::MAX_SPLIT)) ? 3'(pgb_pkg::MAX_SPLIT) : across_ff;
      ay_c = (down_ff == 3'd0) ? 3'd1 :
             (down_ff > 3'(pgb_pkg::MAX_SPLIT)) ? 3'(pgb_pkg::MAX_SPLIT) : down_ff;
      ax = ({4'b0, ax_c} > w) ? w[2:0] : ax_c;
      ay = ({4'b0, ay_c} > h) ? h[2:0] : ay_c;
      w3 = {8'b0, w} * 15'd171;
      h3 = {8'b0, h} * 15'd171;
      case (ax)
         3'd2:    sx = {1'b0, w[6:1]};
         3'd3:    sx = {1'b0, w3[14:9]};
         3'd4:    sx = {2'b0, w[6:2]};
         default: sx = w;
      endcase
      case (ay)
         3'd2:    sy = {1'b0, h[6:1]};
         3'd3:    sy = {1'b0, h3[14:9]};
         3'd4:    sy = {2'b0, h[6:2]};
         default: sy = h;
      endcase
      bx1 = {2'b0, sx};
      bx2 = {1'b0, sx, 1'b0};
      bx3 = bx1 + bx2;
      by1 = {2'b0, sy};
      by2 = {1'b0, sy, 1'b0};
      by3 = by1 + by2;
      rc = 2'(((ax > 3'd1) && ({2'b0, col_ff} >= bx1)) ? 1 : 0)
         + 2'(((ax > 3'd2) && ({2'b0, col_ff} >= bx2)) ? 1 : 0)
         + 2'(((ax > 3'd3) && ({2'b0, col_ff} >= bx3)) ? 1 : 0);
      rr = 2'(((ay > 3'd1) && ({2'b0, row_ff} >= by1)) ? 1 : 0)
         + 2'(((ay > 3'd2) && ({2'b0, row_ff} >= by2)) ? 1 : 0)
         + 2'(((ay > 3'd3) && ({2'b0, row_ff} >= by3)) ? 1 : 0);
   end

   // region count minus one goes to the drain sequencer
   always_comb begin
      logic [5:0] nreg;
      nreg = {3'b0, ax} * {3'b0, ay};
      geom.nreg_last = 4'(nreg - 6'd1);
      geom.run_clear = csr_hit;
   end

   assign csr_hit   = csr_we && (csr_index <= pgb_pkg::CSR_REGIONS_DOWN);
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;
   assign pix_push  = q_push && (req_action == pgb_pkg::ACT_PIXEL);
   assign col_wrap  = (col_ff == w - 7'd1);
   assign row_wrap  = (row_ff == h - 7'd1);

   always_comb begin
      q_entry.action    = req_action;
      q_entry.slot      = req_param_slot;
      q_entry.value     = req_param_value;
      q_entry.region    = ({2'b0, rr} * {1'b0, ax}) + {2'b0, rc};
      q_entry.intensity = req_intensity;
      q_entry.gradient  = req_out_gradient;
      q_entry.patch_end = col_wrap && row_wrap;
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      across_in = across_ff;
      down_in   = down_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         case (csr_index)
            pgb_pkg::CSR_PATCH_WIDTH:    width_in  = csr_data;
            pgb_pkg::CSR_PATCH_HEIGHT:   height_in = csr_data;
            pgb_pkg::CSR_REGIONS_ACROSS: across_in = csr_data[2:0];
            pgb_pkg::CSR_REGIONS_DOWN:   down_in   = csr_data[2:0];
            default: ;
         endcase
      end
      if (csr_hit) begin
         col_in = 7'd0;
         row_in = 7'd0;
      end else if (pix_push) begin
         if (col_wrap) begin
            col_in = 7'd0;
            row_in = row_wrap ? 7'd0 : row_ff + 7'd1;
         end else begin
            col_in = col_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 7'd50;
         height_ff <= 7'd50;
         across_ff <= 3'd3;
         down_ff   <= 3'd3;
         col_ff    <= 7'd0;
         row_ff    <= 7'd0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         across_ff <= across_in;
         down_ff   <= down_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

/* rtl/pgb_queue.sv */
// ----------------------------------------------------------------------------
// pgb_queue
// Four-entry request queue between the classifier and the arithmetic.
// ----------------------------------------------------------------------------
module pgb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pgb_pkg::entry_type entry_in,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output pgb_pkg::entry_type entry_out
);

   pgb_pkg::entry_type slots_ff [4];
   logic [1:0] head_ff, head_in;
   logic [1:0] tail_ff, tail_in;
   logic [2:0] count_ff, count_in;

   assign full      = (count_ff == 3'd4);
   assign not_empty = (count_ff != 3'd0);
   assign entry_out = slots_ff[head_ff];

   always_comb begin
      head_in  = pop  ? head_ff + 2'd1 : head_ff;
      tail_in  = push ? tail_ff + 2'd1 : tail_ff;
      count_in = count_ff + (push ? 3'd1 : 3'd0) - (pop ? 3'd1 : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[tail_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 2'd0;
         tail_ff  <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

/* rtl/pgb_back.sv */
// ----------------------------------------------------------------------------
// pgb_back
// Parameter store, products, rounding, accumulation and the sum drain.
// ----------------------------------------------------------------------------
module pgb_back (
   input  logic                clock,
   input  logic                reset,
   input  pgb_pkg::geom_type   geom,
   input  logic                q_valid,
   input  pgb_pkg::entry_type  q_entry,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_kind,
   output logic signed [31:0]  rsp_pixel_out,
   output logic signed [23:0]  rsp_pixel_jacobian,
   output logic [4:0]          rsp_sum_index,
   output logic signed [47:0]  rsp_sum_value,
   output logic                rsp_last
);

   pgb_pkg::back_state_type state_ff, state_in;

   logic signed [15:0] gain_ff [pgb_pkg::MAX_REGIONS];
   logic signed [23:0] bias_ff;
   logic signed [47:0] sums_ff [pgb_pkg::MAX_REGIONS];
   logic signed [31:0] bias_sum_ff;

   logic               s1_valid_ff, s1_valid_in;
   logic signed [33:0] s1_prod_pix_ff;
   logic signed [32:0] s1_prod_jac_ff;
   logic signed [32:0] s1_prod_acc_ff;
   logic signed [15:0] s1_grad_ff;
   logic signed [23:0] s1_bias_ff;
   logic [3:0]         s1_region_ff;
   logic               s1_end_ff;

   logic [4:0] drain_idx_ff, drain_idx_in;

   logic               out_valid_ff, out_valid_in;
   logic [1:0]         out_kind_ff, out_kind_in;
   logic signed [31:0] out_pix_ff, out_pix_in;
   logic signed [23:0] out_jac_ff, out_jac_in;
   logic [4:0]         out_idx_ff, out_idx_in;
   logic signed [47:0] out_sum_ff, out_sum_in;
   logic               out_last_ff, out_last_in;

   logic out_free, s1_adv, s1_free, pop_pixel, pop_load;
   logic drain_emit, drain_bias, out_load;

   logic signed [16:0] gain;
   logic signed [16:0] inten_s;
   logic signed [34:0] pix_round;
   logic signed [33:0] jac_round;
   logic signed [35:0] pix_full;
   logic signed [31:0] pix_sat;
   logic signed [23:0] jac_sat;
   logic signed [48:0] acc_full;
   logic signed [47:0] acc_sat;
   logic signed [32:0] bsum_full;
   logic signed [31:0] bsum_sat;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s1_adv     = (state_ff == pgb_pkg::BACK_RUN) && s1_valid_ff && out_free;
   assign s1_free    = !s1_valid_ff || s1_adv;
   assign q_pop      = q_valid && s1_free;
   assign pop_pixel  = q_pop && (q_entry.action == pgb_pkg::ACT_PIXEL);
   assign pop_load   = q_pop && (q_entry.action == pgb_pkg::ACT_LOAD);
   assign drain_emit = (state_ff == pgb_pkg::BACK_DRAIN) && out_free;
   assign drain_bias = drain_emit && (drain_idx_ff > {1'b0, geom.nreg_last});
   assign out_load   = s1_adv || drain_emit;

   // products, taken as the request leaves the queue
   always_comb begin
      gain    = 17'sd16384 + 17'(gain_ff[q_entry.region]);
      inten_s = $signed({1'b0, q_entry.intensity});
   end

   always_comb begin
      pix_round = 35'(s1_prod_pix_ff) + 35'sd8192;
      jac_round = 34'(s1_prod_jac_ff) + 34'sd8192;
      pix_full  = 36'($signed(pix_round[34:14])) + 36'(s1_bias_ff);
      if (pix_full > 36'sd2147483647) begin
         pix_sat = 32'sh7fffffff;
      end else if (pix_full < -36'sd2147483648) begin
         pix_sat = 32'sh80000000;
      end else begin
         pix_sat = pix_full[31:0];
      end
      // a rounded 17 by 16 bit product always fits the jacobian field
      jac_sat = 24'($signed(jac_round[33:14]));
      acc_full = 49'(sums_ff[s1_region_ff]) + 49'(s1_prod_acc_ff);
      if (acc_full[48] != acc_full[47]) begin
         acc_sat = acc_full[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
      end else begin
         acc_sat = acc_full[47:0];
      end
      bsum_full = 33'(bias_sum_ff) + 33'(s1_grad_ff);
      if (bsum_full[32] != bsum_full[31]) begin
         bsum_sat = bsum_full[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
      end else begin
         bsum_sat = bsum_full[31:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pgb_pkg::BACK_RUN: begin
            if (s1_adv && s1_end_ff) begin
               state_in = pgb_pkg::BACK_DRAIN;
            end
         end
         pgb_pkg::BACK_DRAIN: begin
            if (drain_bias) begin
               state_in = pgb_pkg::BACK_RUN;
            end
         end
         default: state_in = pgb_pkg::BACK_RUN;
      endcase
      if (geom.run_clear) begin
         state_in = pgb_pkg::BACK_RUN;
      end
   end

   always_comb begin
      out_kind_in  = out_kind_ff;
      out_pix_in   = out_pix_ff;
      out_jac_in   = out_jac_ff;
      out_idx_in   = out_idx_ff;
      out_sum_in   = out_sum_ff;
      out_last_in  = out_last_ff;
      drain_idx_in = drain_idx_ff;
      case (state_ff)
         pgb_pkg::BACK_RUN: begin
            drain_idx_in = 5'd0;
            if (s1_adv) begin
               out_kind_in = pgb_pkg::KIND_PIXEL;
               out_pix_in  = pix_sat;
               out_jac_in  = jac_sat;
               out_idx_in  = 5'd0;
               out_sum_in  = 48'sd0;
               out_last_in = !s1_end_ff;
            end
         end
         pgb_pkg::BACK_DRAIN: begin
            if (drain_emit) begin
               out_pix_in   = 32'sd0;
               out_jac_in   = 24'sd0;
               drain_idx_in = drain_idx_ff + 5'd1;
               if (drain_bias) begin
                  out_kind_in = pgb_pkg::KIND_BIAS_SUM;
                  out_idx_in  = pgb_pkg::BIAS_SLOT;
                  out_sum_in  = 48'(bias_sum_ff);
                  out_last_in = 1'b1;
               end else begin
                  out_kind_in = pgb_pkg::KIND_GAIN_SUM;
                  out_idx_in  = drain_idx_ff;
                  out_sum_in  = sums_ff[drain_idx_ff[3:0]];
                  out_last_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
      out_valid_in = out_load || (out_valid_ff && rsp_stall);
      s1_valid_in  = pop_pixel || (s1_valid_ff && !s1_adv);
   end

   always_ff @(posedge clock) begin
      if (pop_pixel) begin
         s1_prod_pix_ff <= gain * inten_s;
         s1_prod_jac_ff <= $signed(q_entry.gradient) * gain;
         s1_prod_acc_ff <= $signed(q_entry.gradient) * inten_s;
         s1_grad_ff     <= $signed(q_entry.gradient);
         s1_bias_ff     <= bias_ff;
         s1_region_ff   <= q_entry.region;
         s1_end_ff      <= q_entry.patch_end;
      end
      out_kind_ff <= out_kind_in;
      out_pix_ff  <= out_pix_in;
      out_jac_ff  <= out_jac_in;
      out_idx_ff  <= out_idx_in;
      out_sum_ff  <= out_sum_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pgb_pkg::BACK_RUN;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         drain_idx_ff <= 5'd0;
         bias_ff      <= 24'sd0;
         bias_sum_ff  <= 32'sd0;
         for (int i = 0; i < pgb_pkg::MAX_REGIONS; i++) begin
            gain_ff[i] <= 16'sd0;
            sums_ff[i] <= 48'sd0;
         end
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         drain_idx_ff <= drain_idx_in;
         if (pop_load) begin
            if (q_entry.slot < pgb_pkg::BIAS_SLOT) begin
               gain_ff[q_entry.slot[3:0]] <= $signed(q_entry.value[15:0]);
            end else if (q_entry.slot == pgb_pkg::BIAS_SLOT) begin
               bias_ff <= $signed(q_entry.value);
            end
         end
         if (geom.run_clear || drain_bias) begin
            bias_sum_ff <= 32'sd0;
            for (int i = 0; i < pgb_pkg::MAX_REGIONS; i++) begin
               sums_ff[i] <= 48'sd0;
            end
         end else if (s1_adv) begin
            bias_sum_ff           <= bsum_sat;
            sums_ff[s1_region_ff] <= acc_sat;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_pixel_out      = out_pix_ff;
   assign rsp_pixel_jacobian = out_jac_ff;
   assign rsp_sum_index      = out_idx_ff;
   assign rsp_sum_value      = out_sum_ff;
   assign rsp_last           = out_last_ff;

endmodule

/* rtl/piecewise_gain_bias_pixel_engine.sv */
// ----------------------------------------------------------------------------
// piecewise_gain_bias_pixel_engine
// Per-region gain and shared bias applied to a raster patch, with sums.
// ----------------------------------------------------------------------------
// A request either loads a gain offset or the bias (no response) or carries
// one pixel in raster order (one pixel response). The pixel request that
// closes the patch is followed by one gain sum per region and then the bias
// sum, marked last. Loads and pixels are taken one per cycle while the
// four-entry queue has room; a pixel response passes through the queue,
// the product register and the output register, and the end of a patch
// holds the pixel path while the region sums and then the bias sum drain
// through the single output register.
module piecewise_gain_bias_pixel_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [6:0]         csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [4:0]         req_param_slot,
   input  logic signed [23:0] req_param_value,
   input  logic [15:0]        req_intensity,
   input  logic signed [15:0] req_out_gradient,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [31:0] rsp_pixel_out,
   output logic signed [23:0] rsp_pixel_jacobian,
   output logic [4:0]         rsp_sum_index,
   output logic signed [47:0] rsp_sum_value,
   output logic               rsp_last
);

   logic               q_push, q_full, q_pop, q_valid;
   pgb_pkg::entry_type q_in, q_out;
   pgb_pkg::geom_type  geom;

   pgb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_param_slot   (req_param_slot),
      .req_param_value  (req_param_value),
      .req_intensity    (req_intensity),
      .req_out_gradient (req_out_gradient),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_in),
      .geom             (geom)
   );

   pgb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .entry_in  (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .entry_out (q_out)
   );

   pgb_back u_back (
      .clock              (clock),
      .reset              (reset),
      .geom               (geom),
      .q_valid            (q_valid),
      .q_entry            (q_out),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_pixel_out      (rsp_pixel_out),
      .rsp_pixel_jacobian (rsp_pixel_jacobian),
      .rsp_sum_index      (rsp_sum_index),
      .rsp_sum_value      (rsp_sum_value),
      .rsp_last           (rsp_last)
   );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the piecewise gain/bias pixel engine.
// ----------------------------------------------------------------------------
// A short directed table covers the field extremes, bias and gain-offset
// loads, ignored slots and the first pixels after reset. A series of patch
// geometries follows, the register extremes among them. Each geometry gets a
// burst of random pixels and loads. Every response is checked against a
// behavioural model of the region gains, the bias, the per-region gain sums
// and the bias sum. Both handshakes idle at random, apart from one calm
// stretch.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [6:0]         csr_data;
   logic               req_valid;
   logic               req_stall;
   logic               req_action;
   logic [4:0]         req_param_slot;
   logic signed [23:0] req_param_value;
   logic [15:0]        req_intensity;
   logic signed [15:0] req_out_gradient;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_kind;
   logic signed [31:0] rsp_pixel_out;
   logic signed [23:0] rsp_pixel_jacobian;
   logic [4:0]         rsp_sum_index;
   logic signed [47:0] rsp_sum_value;
   logic               rsp_last;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] pixel_out;
      logic signed [23:0] jacobian;
      logic [4:0]         sum_index;
      logic signed [47:0] sum_value;
      logic               last;
   } engine_result_type;

   typedef struct {
      logic        action;
      logic [4:0]  slot;
      logic [23:0] value;
      logic [15:0] intensity;
      logic [15:0] gradient;
      bit          typed;
      int          pixel_out;
      int          jacobian;
   } directed_row_type;

   localparam int NUM_DIRECTED = 16;
   localparam int NUM_ITEMS    = 280;

   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{pgb_pkg::ACT_PIXEL, 5'd0,  24'h000000, 16'h0000, 16'h0000, 1, 0,       0},
      '{pgb_pkg::ACT_PIXEL, 5'd0,  24'h000000, 16'hFFFF, 16'h8000, 1, 65535,   -32768},
      '{pgb_pkg::ACT_PIXEL, 5'd0,  24'h000000, 16'h8000, 16'h7FFF, 1, 32768,   32767},
      '{pgb_pkg::ACT_LOAD,  5'd16, 24'h7FFFFF, 16'h1234, 16'h4321, 0, 0,       0},
      '{pgb_pkg::ACT_PIXEL, 5'd31, 24'hFFFFFF, 16'h0100, 16'h0100, 1, 8388863, 256},
      '{pgb_pkg::ACT_LOAD,  5'd16, 24'h800000, 16'hFFFF, 16'hFFFF, 0, 0,       0},
      '{pgb_pkg::ACT_LOAD,  5'd0,  24'hAB7FFF, 16'h0000, 16'h0000, 0, 0,       0},
      '{pgb_pkg::ACT_PIXEL, 5'd0,  24'h000000, 16'hFFFF, 16'h7FFF, 0, 0,       0},
      '{pgb_pkg::ACT_LOAD,  5'd0,  24'h008000, 16'h0000, 16'h0000, 0, 0,       0},
      '{pgb_pkg::ACT_PIXEL, 5'd0,  24'h000000, 16'hFFFF, 16'h8000, 0, 0,       0},
      '{pgb_pkg::ACT_LOAD,  5'd17, 24'h123456, 16'h0000, 16'h0000, 0, 0,       0},
      '{pgb_pkg::ACT_LOAD,  5'd31, 24'hFFFFFF, 16'h0000, 16'h0000, 0, 0,       0},
      '{pgb_pkg::ACT_LOAD,  5'd15, 24'h005555, 16'h0000, 16'h0000, 0, 0,       0},
      '{pgb_pkg::ACT_LOAD,  5'd16, 24'h000000, 16'h0000, 16'h0000, 0, 0,       0},
      '{pgb_pkg::ACT_PIXEL, 5'd0,  24'h000000, 16'h5A5A, 16'hA5A5, 0, 0,       0},
      '{pgb_pkg::ACT_PIXEL, 5'd0,  24'h000000, 16'hFFFF, 16'hFFFF, 0, 0,       0}
   };

   logic [6:0] geometry [4][4] = '{
      '{7'd127, 7'd1,  7'd7, 7'd7},
      '{7'd0,   7'd0,  7'd0, 7'd0},
      '{7'd64,  7'd2,  7'd4, 7'd4},
      '{7'd4,   7'd64, 7'd1, 7'd4}
   };

   // model state
   logic [6:0]         cfg_width, cfg_height;
   logic [2:0]         cfg_across, cfg_down;
   logic signed [15:0] gain_offsets [pgb_pkg::MAX_REGIONS];
   longint             bias_value;
   int                 col_count, row_count;
   longint             region_sums [pgb_pkg::MAX_REGIONS];
   longint             bias_sum;

   engine_result_type expected_results [$];
   int  mismatches = 0;
   int  pixels_sent = 0, loads_sent = 0, patches_closed = 0, csr_writes = 0;
   bit  calm = 0;

   piecewise_gain_bias_pixel_engine DUT (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("TEST FAILED");
      $finish;
   end

   function automatic longint saturate(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic longint round_q14(longint v);
      return (v + 8192) >>> 14;
   endfunction

   function automatic int clamp(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void clear_patch();
      col_count = 0;
      row_count = 0;
      bias_sum = 0;
      foreach (region_sums[i]) region_sums[i] = 0;
   endfunction

   function automatic void predict_request(logic action, logic [4:0] slot,
                                           logic [23:0] value, logic [15:0] intensity,
                                           logic [15:0] gradient);
      int w, h, ax, ay, sx, sy, rc, rr, reg_idx, nreg;
      longint gain, inten, grad, pix, jac;
      w  = clamp(cfg_width, 1, pgb_pkg::MAX_SIDE);
      h  = clamp(cfg_height, 1, pgb_pkg::MAX_SIDE);
      ax = clamp(cfg_across, 1, pgb_pkg::MAX_SPLIT);
      ay = clamp(cfg_down, 1, pgb_pkg::MAX_SPLIT);
      if (ax > w) ax = w;
      if (ay > h) ay = h;
      if (action == pgb_pkg::ACT_LOAD) begin
         if (slot < pgb_pkg::MAX_REGIONS) gain_offsets[slot] = value[15:0];
         else if (slot == pgb_pkg::BIAS_SLOT) bias_value = longint'(signed'(value));
         return;
      end
      if (col_count >= w) col_count = 0;
      if (row_count >= h) row_count = 0;
      sx = w / ax;
      sy = h / ay;
      rc = col_count / sx;
      if (rc > ax - 1) rc = ax - 1;
      rr = row_count / sy;
      if (rr > ay - 1) rr = ay - 1;
      reg_idx = rr * ax + rc;
      inten = longint'(intensity);
      grad  = longint'(signed'(gradient));
      gain  = 16384 + longint'(gain_offsets[reg_idx]);
      pix = saturate(round_q14(gain * inten) + bias_value, 32);
      jac = saturate(round_q14(grad * gain), 24);
      region_sums[reg_idx] = saturate(region_sums[reg_idx] + grad * inten, 48);
      bias_sum = saturate(bias_sum + grad, 32);
      col_count++;
      if (col_count >= w) begin
         col_count = 0;
         row_count++;
      end
      if (row_count < h) begin
         expected_results.push_back('{pgb_pkg::KIND_PIXEL, pix[31:0], jac[23:0], 5'd0,
                                      48'd0, 1'b1});
         return;
      end
      expected_results.push_back('{pgb_pkg::KIND_PIXEL, pix[31:0], jac[23:0], 5'd0,
                                   48'd0, 1'b0});
      nreg = ax * ay;
      for (int r = 0; r < nreg; r++)
         expected_results.push_back('{pgb_pkg::KIND_GAIN_SUM, 32'd0, 24'd0, r[4:0],
                                      region_sums[r][47:0], 1'b0});
      expected_results.push_back('{pgb_pkg::KIND_BIAS_SUM, 32'd0, 24'd0, pgb_pkg::BIAS_SLOT,
                                   bias_sum[47:0], 1'b1});
      patches_closed++;
      clear_patch();
   endfunction

   // response checker
   always @(posedge clock) begin
      engine_result_type got, want;
      if (!reset) begin
         rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 20);
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_kind, rsp_pixel_out, rsp_pixel_jacobian, rsp_sum_index,
                    rsp_sum_value, rsp_last};
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response kind=%0d pix=%0d", got.kind, got.pixel_out);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: exp kind=%0d pix=%0d jac=%0d idx=%0d sum=%0d last=%0d",
                              want.kind, want.pixel_out, want.jacobian, want.sum_index,
                              want.sum_value, want.last);
                     $display("          got kind=%0d pix=%0d jac=%0d idx=%0d sum=%0d last=%0d",
                              got.kind, got.pixel_out, got.jacobian, got.sum_index,
                              got.sum_value, got.last);
                  end
               end
            end
         end
      end
   end

   // may idle before driving, returns at the accepting edge
   task automatic send_request(logic action, logic [4:0] slot, logic [23:0] value,
                               logic [15:0] intensity, logic [15:0] gradient);
      if (!calm && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= action;
      req_param_slot   <= slot;
      req_param_value  <= value;
      req_intensity    <= intensity;
      req_out_gradient <= gradient;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(action, slot, value, intensity, gradient);
      if (action == pgb_pkg::ACT_PIXEL) pixels_sent++;
      else loads_sent++;
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] index, logic [6:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      case (index)
         pgb_pkg::CSR_PATCH_WIDTH:    cfg_width  = data;
         pgb_pkg::CSR_PATCH_HEIGHT:   cfg_height = data;
         pgb_pkg::CSR_REGIONS_ACROSS: cfg_across = data[2:0];
         pgb_pkg::CSR_REGIONS_DOWN:   cfg_down   = data[2:0];
         default: ;
      endcase
      clear_patch();
      csr_writes++;
   endtask

   task automatic random_request();
      logic [4:0] slot;
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) slot = 5'($urandom_range(15));
      else if (pick < 85) slot = pgb_pkg::BIAS_SLOT;
      else slot = 5'($urandom_range(31, 17));
      if ($urandom_range(99) < 85)
         send_request(pgb_pkg::ACT_PIXEL, 5'($urandom), 24'($urandom), 16'($urandom),
                      16'($urandom));
      else
         send_request(pgb_pkg::ACT_LOAD, slot, 24'($urandom), 16'($urandom),
                      16'($urandom));
   endtask

   initial begin
      int phase, count, w, h, remaining;
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= pgb_pkg::CSR_PATCH_WIDTH;
      csr_data         <= '0;
      req_valid        <= 1'b0;
      req_action       <= pgb_pkg::ACT_LOAD;
      req_param_slot   <= '0;
      req_param_value  <= '0;
      req_intensity    <= '0;
      req_out_gradient <= '0;
      rsp_stall        <= 1'b0;
      cfg_width  = 50;
      cfg_height = 50;
      cfg_across = 3;
      cfg_down   = 3;
      foreach (gain_offsets[i]) gain_offsets[i] = 0;
      bias_value = 0;
      clear_patch();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].action, directed_rows[i].slot,
                      directed_rows[i].value, directed_rows[i].intensity,
                      directed_rows[i].gradient);
         if (directed_rows[i].typed) begin
            void'(expected_results.pop_back());
            expected_results.push_back('{pgb_pkg::KIND_PIXEL, directed_rows[i].pixel_out,
                                         directed_rows[i].jacobian[23:0], 5'd0,
                                         48'd0, 1'b1});
         end
      end

      phase = 0;
      while (pixels_sent + loads_sent < NUM_ITEMS) begin
         drain_and_settle();
         calm = (phase == 3 || phase == 4);
         if (phase < 4) begin
            write_register(pgb_pkg::CSR_PATCH_WIDTH,    geometry[phase][0]);
            write_register(pgb_pkg::CSR_PATCH_HEIGHT,   geometry[phase][1]);
            write_register(pgb_pkg::CSR_REGIONS_ACROSS, geometry[phase][2]);
            write_register(pgb_pkg::CSR_REGIONS_DOWN,   geometry[phase][3]);
         end else begin
            write_register(pgb_pkg::CSR_PATCH_WIDTH,
                           7'(($urandom_range(9) == 0) ? $urandom : $urandom_range(8)));
            write_register(pgb_pkg::CSR_PATCH_HEIGHT,
                           7'(($urandom_range(9) == 0) ? $urandom : $urandom_range(8)));
            write_register(pgb_pkg::CSR_REGIONS_ACROSS, 7'($urandom_range(7)));
            write_register(pgb_pkg::CSR_REGIONS_DOWN,   7'($urandom_range(7)));
         end
         csr_we <= 1'b0;
         w = clamp(cfg_width, 1, pgb_pkg::MAX_SIDE);
         h = clamp(cfg_height, 1, pgb_pkg::MAX_SIDE);
         count = (w * h > 60) ? 75 : $urandom_range(2 * w * h + 4, 5);
         remaining = NUM_ITEMS - (pixels_sent + loads_sent);
         if (count > remaining) count = remaining;
         repeat (count) random_request();
         phase++;
      end
      calm = 0;
      drain_and_settle();

      $display("covered %0d pixels, %0d loads, %0d register writes over %0d geometries",
               pixels_sent, loads_sent, csr_writes, phase);
      $display("%0d patches closed with sums, %0d mismatches", patches_closed, mismatches);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/pgb_pkg.sv
rtl/pgb_front.sv
rtl/pgb_queue.sv
rtl/pgb_back.sv
rtl/piecewise_gain_bias_pixel_engine.sv
tb/testbench.sv
